// ===== src/mbrp_pkg.sv =====
// Package for the boot sector partition table parser.
// Holds sector layout constants, partition type codes and the shared structs.
// No dependencies.
`timescale 1ns / 1ps

package mbrp_pkg;

  // Sector layout, in byte offsets from the start of the sector.
  localparam logic [9:0] SECTOR_BYTES    = 10'd512;
  localparam logic [9:0] TABLE_START     = 10'h1BE;
  localparam logic [9:0] SIG_OFFSET      = 10'h1FE;
  localparam logic [9:0] SIG_HIGH_OFFSET = 10'h1FF;

  // The 64 table bytes are kept as 16 little-endian words, four per entry.
  localparam int TableWords = 16;

  // Signature bytes.
  localparam logic [7:0] SIG_LOW_BYTE  = 8'h55;
  localparam logic [7:0] SIG_HIGH_BYTE = 8'hAA;

  // Partition type codes.
  localparam logic [7:0] TYPE_EMPTY   = 8'h00;
  localparam logic [7:0] TYPE_EXT_CHS = 8'h05;
  localparam logic [7:0] TYPE_EXT_LBA = 8'h0F;

  // Result kinds.
  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Configuration defaults.
  localparam int         MaxPartitions     = 16;
  localparam logic [4:0] MAX_ENTRIES_RESET = 5'd16;

  // One finished sector, handed from the byte front end to the table walker.
  typedef struct packed {
    logic        is_ext;
    logic [31:0] lba;
    logic        sig_ok;
  } job_t;

  // Word write into the partition table memory.
  typedef struct packed {
    logic        we;
    logic [3:0]  addr;
    logic [31:0] data;
  } tbl_wr_t;

  function automatic logic is_ext_type(input logic [7:0] t);
    return (t == TYPE_EXT_CHS) || (t == TYPE_EXT_LBA);
  endfunction

endpackage

// ===== src/mbrp_if.sv =====
// Handshake interfaces of the partition table parser: sector bytes in,
// results out and the configuration write channel. No dependencies.
`timescale 1ns / 1ps

interface mbrp_sector_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        ebr_sector;
  logic [31:0] sector_lba;

  modport source (output valid, data_byte, first_byte, ebr_sector, sector_lba,
                  input ready);
  modport sink (input valid, data_byte, first_byte, ebr_sector, sector_lba,
                output ready);
endinterface

interface mbrp_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  boot_flag;
  logic [7:0]  part_type;
  logic [31:0] start_lba;
  logic [31:0] sector_total;
  logic [31:0] next_sector_lba;
  logic        more_to_scan;
  logic        signature_ok;
  logic [4:0]  entries_total;
  logic        last;

  modport source (output valid, kind, boot_flag, part_type, start_lba, sector_total,
                  next_sector_lba, more_to_scan, signature_ok, entries_total, last,
                  input ready);
  modport sink (input valid, kind, boot_flag, part_type, start_lba, sector_total,
                next_sector_lba, more_to_scan, signature_ok, entries_total, last,
                output ready);
endinterface

interface mbrp_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] max_entries;

  modport source (output valid, max_entries, input ready);
  modport sink (input valid, max_entries, output ready);
endinterface

// ===== src/mbrp_front.sv =====
// Byte front end: counts sector bytes, packs table bytes into words and
// hands each finished sector on as a job. Depends on mbrp_pkg and mbrp_if.
`timescale 1ns / 1ps

module mbrp_front import mbrp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  mbrp_sector_if.sink   sector,
  input  logic          back_busy,
  output job_t          job,
  output logic          job_push,
  output tbl_wr_t       tbl_wr
);

  logic [9:0]  byte_index;
  logic        is_ext;
  logic [31:0] this_lba;
  logic [7:0]  sig_low;
  logic [23:0] asm_word;

  logic        accept;
  logic [9:0]  idx;
  logic        active;
  logic        in_table;
  logic [5:0]  offset;
  logic        in_zone;

  // Hold off bytes from the table start to the sector end while the walker still reads the previous table.
  assign in_zone      = (byte_index >= TABLE_START) && !byte_index[9];
  assign sector.ready = !(in_zone && back_busy);
  assign accept       = sector.valid && sector.ready;

  // Position of the byte now offered; a first byte restarts the count.
  assign idx      = sector.first_byte ? 10'd0 : byte_index;
  assign active   = !idx[9];
  assign in_table = active && (idx >= TABLE_START) && (idx < SIG_OFFSET);
  assign offset   = 6'(idx - TABLE_START);

  // A table word is written when its fourth byte arrives.
  assign tbl_wr.we   = accept && in_table && (offset[1:0] == 2'd3);
  assign tbl_wr.addr = offset[5:2];
  assign tbl_wr.data = {sector.data_byte, asm_word};

  // The last byte of the sector closes the job.
  assign job_push   = accept && active && (idx == SIG_HIGH_OFFSET);
  assign job.is_ext = is_ext;
  assign job.lba    = this_lba;
  assign job.sig_ok = (sig_low == SIG_LOW_BYTE) && (sector.data_byte == SIG_HIGH_BYTE);

  // Byte counter and per-sector attributes.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= SECTOR_BYTES;
      is_ext     <= 1'b0;
      this_lba   <= 32'd0;
      sig_low    <= 8'd0;
    end else if (accept) begin
      if (sector.first_byte) begin
        is_ext   <= sector.ebr_sector;
        this_lba <= sector.sector_lba;
      end
      if (active) begin
        byte_index <= idx + 10'd1;
      end
      if (active && (idx == SIG_OFFSET)) begin
        sig_low <= sector.data_byte;
      end
    end
  end

  // Collect the low three bytes of each table word.
  always_ff @(posedge clk) begin
    if (accept && in_table) begin
      case (offset[1:0])
        2'd0: asm_word[7:0]   <= sector.data_byte;
        2'd1: asm_word[15:8]  <= sector.data_byte;
        2'd2: asm_word[23:16] <= sector.data_byte;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/mbrp_queue.sv =====
// Two-entry job queue between the byte front end and the table walker.
// Depends on mbrp_pkg.
`timescale 1ns / 1ps

module mbrp_queue import mbrp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  job_t push_data,
  input  logic push,
  output job_t pop_data,
  output logic pop_valid,
  input  logic pop
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign pop_valid = (count != 2'd0);
  assign pop_data  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && pop_valid) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !(pop && pop_valid)) begin
        count <= count + 2'd1;
      end else if (!push && pop && pop_valid) begin
        count <= count - 2'd1;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/mbrp_back.sv =====
// Table walker: holds the partition table memory, walks the entries of one
// job and emits entry and summary items. Depends on mbrp_pkg and mbrp_if.
`timescale 1ns / 1ps

module mbrp_back import mbrp_pkg::*; #(
  parameter int MAX_PARTITIONS = MaxPartitions
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [4:0]    max_entries,
  input  tbl_wr_t       tbl_wr,
  input  job_t          job,
  input  logic          job_valid,
  output logic          job_pop,
  output logic          busy,
  mbrp_result_if.source result
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_LOAD    = 3'd1;
  localparam logic [2:0] ST_WAIT    = 3'd2;
  localparam logic [2:0] ST_EVAL    = 3'd3;
  localparam logic [2:0] ST_SUMMARY = 3'd4;

  logic [31:0] table_mem [TableWords];
  logic [31:0] rdata;
  logic        rd_valid;
  logic [1:0]  rd_word;
  logic [31:0] ent_words [4];

  logic [2:0]  state;
  logic [1:0]  ent;
  logic [1:0]  wcnt;
  job_t        cur;
  logic [4:0]  entry_count;
  logic [31:0] ext_base;
  logic        more_r;
  logic [31:0] next_r;

  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_boot;
  logic [7:0]  out_type;
  logic [31:0] out_start;
  logic [31:0] out_total;
  logic [31:0] out_next;
  logic        out_more;
  logic        out_sig;
  logic [4:0]  out_count;
  logic        out_last;

  logic [4:0]  lim;
  logic        below_lim;
  logic        can_emit;
  logic [7:0]  w_boot;
  logic [7:0]  w_type;
  logic [31:0] w_start;
  logic [31:0] w_size;
  logic        eval_emit;
  logic [4:0]  count_after;
  logic        emit_ent;
  logic        emit_sum;
  logic        sum_more;
  logic [31:0] sum_next;
  logic [31:0] ent_start;

  // Limit is the smaller of the register and the build-time maximum.
  assign lim = (32'(max_entries) > MAX_PARTITIONS) ? 5'(MAX_PARTITIONS) : max_entries;
  assign below_lim = entry_count < lim;

  // The output register is free when empty or being taken this cycle.
  assign can_emit = !out_valid || result.ready;

  assign job_pop = (state == ST_IDLE) && job_valid;
  assign busy    = (state != ST_IDLE);

  // Fields of the entry just loaded.
  assign w_boot  = ent_words[0][7:0];
  assign w_type  = ent_words[1][7:0];
  assign w_start = ent_words[2];
  assign w_size  = ent_words[3];

  // Decide whether the loaded entry is reported.
  always_comb begin
    if (!cur.is_ext) begin
      eval_emit = (w_type != TYPE_EMPTY) && !is_ext_type(w_type);
    end else begin
      eval_emit = (ent == 2'd0) && (w_type != TYPE_EMPTY) && (w_start != 32'd0);
    end
  end

  assign count_after = entry_count + 5'(eval_emit);
  assign emit_ent    = (state == ST_EVAL) && eval_emit && can_emit;
  assign emit_sum    = (state == ST_SUMMARY) && can_emit;
  assign ent_start   = cur.is_ext ? (cur.lba + w_start) : w_start;

  // Summary link fields.
  always_comb begin
    if (!cur.is_ext) begin
      sum_more = (ext_base != 32'd0) && below_lim;
      sum_next = sum_more ? ext_base : 32'd0;
    end else begin
      sum_more = more_r;
      sum_next = next_r;
    end
  end

  // Table memory: word writes from the front end, registered reads.
  always_ff @(posedge clk) begin
    if (tbl_wr.we) begin
      table_mem[tbl_wr.addr] <= tbl_wr.data;
    end
    if (state == ST_LOAD) begin
      rdata <= table_mem[{ent, wcnt}];
    end
  end

  // Capture read words into the entry holding register.
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      ent_words[rd_word] <= rdata;
    end
    rd_word <= wcnt;
  end

  // Walker sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      ent         <= 2'd0;
      wcnt        <= 2'd0;
      rd_valid    <= 1'b0;
      entry_count <= 5'd0;
      ext_base    <= 32'd0;
      more_r      <= 1'b0;
      next_r      <= 32'd0;
      cur         <= '0;
    end else begin
      rd_valid <= (state == ST_LOAD);
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            cur    <= job;
            ent    <= 2'd0;
            wcnt   <= 2'd0;
            more_r <= 1'b0;
            next_r <= 32'd0;
            if (!job.is_ext) begin
              entry_count <= 5'd0;
              ext_base    <= 32'd0;
              state       <= (job.sig_ok && (lim != 5'd0)) ? ST_LOAD : ST_SUMMARY;
            end else begin
              state <= (job.sig_ok && below_lim) ? ST_LOAD : ST_SUMMARY;
            end
          end
        end
        ST_LOAD: begin
          wcnt <= wcnt + 2'd1;
          if (wcnt == 2'd3) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (!(eval_emit && !can_emit)) begin
            entry_count <= count_after;
            if (!cur.is_ext) begin
              // Primary entries: extended types only record the chain base.
              if (is_ext_type(w_type)) begin
                ext_base <= w_start;
              end
              ent <= ent + 2'd1;
              if ((ent == 2'd3) || (count_after >= lim)) begin
                state <= ST_SUMMARY;
              end else begin
                state <= ST_LOAD;
              end
            end else if (ent == 2'd0) begin
              // Logical entry done; fetch the link entry.
              ent   <= 2'd1;
              state <= ST_LOAD;
            end else begin
              if (is_ext_type(w_type) && below_lim) begin
                more_r <= 1'b1;
                next_r <= ext_base + w_start;
              end
              state <= ST_SUMMARY;
            end
          end
        end
        ST_SUMMARY: begin
          if (can_emit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ent || emit_sum) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (emit_ent) begin
      out_kind  <= KIND_ENTRY;
      out_boot  <= w_boot;
      out_type  <= w_type;
      out_start <= ent_start;
      out_total <= w_size;
      out_next  <= 32'd0;
      out_more  <= 1'b0;
      out_sig   <= 1'b1;
      out_count <= count_after;
      out_last  <= 1'b0;
    end else if (emit_sum) begin
      out_kind  <= KIND_SUMMARY;
      out_boot  <= 8'd0;
      out_type  <= 8'd0;
      out_start <= 32'd0;
      out_total <= 32'd0;
      out_next  <= sum_next;
      out_more  <= sum_more;
      out_sig   <= cur.sig_ok;
      out_count <= entry_count;
      out_last  <= 1'b1;
    end
  end

  assign result.valid           = out_valid;
  assign result.kind            = out_kind;
  assign result.boot_flag       = out_boot;
  assign result.part_type       = out_type;
  assign result.start_lba       = out_start;
  assign result.sector_total    = out_total;
  assign result.next_sector_lba = out_next;
  assign result.more_to_scan    = out_more;
  assign result.signature_ok    = out_sig;
  assign result.entries_total   = out_count;
  assign result.last            = out_last;

  // The front end never overwrites the table while a job is pending or walked.
  a_no_table_overwrite: assert property (@(posedge clk) disable iff (rst)
    tbl_wr.we |-> (state == ST_IDLE) && !job_valid)
    else $error("table written while a sector is being walked");

  // The walker only leaves idle when a job is waiting.
  a_idle_needs_job: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && !job_valid |=> (state == ST_IDLE))
    else $error("walker started without a job");

  // Evaluation follows a completed entry load.
  a_eval_after_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> ($past(state) == ST_WAIT) || ($past(state) == ST_EVAL))
    else $error("entry evaluated before its words were read");

  // A reported entry always counts itself.
  a_entry_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_ENTRY) |-> (out_count != 5'd0) && !out_last)
    else $error("entry item with zero count or end mark");

endmodule

// ===== src/mbr_ebr_partition_parser.sv =====
// Boot sector partition table parser, top level. Rate: one sector byte per
// cycle, except that table bytes are held off while the walker or its queue is
// busy. After byte 0x1FF the walker takes the sector, reads each entry (four
// reads through the single table memory port, one wait, one decision) and then
// emits the summary; results overlap the next sector. Reset (rst, sync,
// active high) makes the block idle until a first byte and sets max_entries 16.
`timescale 1ns / 1ps

module mbr_ebr_partition_parser import mbrp_pkg::*; #(
  parameter int MAX_PARTITIONS = MaxPartitions
) (
  input  logic          clk,
  input  logic          rst,
  mbrp_sector_if.sink   sector,
  mbrp_result_if.source result,
  mbrp_cfg_if.sink      cfg
);

  logic [4:0] max_entries;
  job_t       push_job;
  logic       push;
  job_t       head_job;
  logic       head_valid;
  logic       pop;
  logic       back_busy;
  tbl_wr_t    tbl_wr;

  // Configuration register; always ready.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RESET;
    end else if (cfg.valid) begin
      max_entries <= cfg.max_entries;
    end
  end

  // Byte front end.
  mbrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .sector    (sector),
    .back_busy (back_busy || head_valid),
    .job       (push_job),
    .job_push  (push),
    .tbl_wr    (tbl_wr)
  );

  // Job queue.
  mbrp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_data (push_job),
    .push      (push),
    .pop_data  (head_job),
    .pop_valid (head_valid),
    .pop       (pop)
  );

  // Table walker.
  mbrp_back #(
    .MAX_PARTITIONS (MAX_PARTITIONS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .max_entries (max_entries),
    .tbl_wr      (tbl_wr),
    .job         (head_job),
    .job_valid   (head_valid),
    .job_pop     (pop),
    .busy        (back_busy),
    .result      (result)
  );

endmodule

// ===== sim/mbr_ebr_partition_parser_tb.sv =====
// Testbench for the boot sector partition table parser.
// Streams master and extended sectors into the block, predicts each result and checks it.
// Depends on mbrp_pkg, the handshake interfaces and mbr_ebr_partition_parser.
`timescale 1ns / 1ps

package mbrp_check_pkg;
  import mbrp_pkg::*;

  // One result item as it leaves the block.
  typedef struct packed {
    logic        kind;
    logic [7:0]  boot_flag;
    logic [7:0]  part_type;
    logic [31:0] start_lba;
    logic [31:0] sector_total;
    logic [31:0] next_sector_lba;
    logic        more_to_scan;
    logic        signature_ok;
    logic [4:0]  entries_total;
    logic        last;
  } part_result_t;

  // Predicts the partition results of the byte stream and checks the block against them.
  class sector_scoreboard;
    int unsigned  byte_pos;
    bit [7:0]     tbl [64];
    bit [7:0]     sig_lo;
    bit           in_ext_sector;
    bit [31:0]    sector_base;
    bit [31:0]    ext_base;
    bit [4:0]     reported;
    bit [4:0]     max_entries;
    bit           chain_more;
    bit [31:0]    chain_next;
    int           errors;
    part_result_t pending_q [$];

    function new();
      byte_pos = SECTOR_BYTES;
      foreach (tbl[i]) tbl[i] = 8'h00;
      sig_lo = 8'h00;
      in_ext_sector = 1'b0;
      sector_base = 32'h0;
      ext_base = 32'h0;
      reported = 5'd0;
      max_entries = MAX_ENTRIES_RESET;
      chain_more = 1'b0;
      chain_next = 32'h0;
      errors = 0;
    endfunction

    function bit [31:0] word_at(int off);
      return {tbl[off + 3], tbl[off + 2], tbl[off + 1], tbl[off]};
    endfunction

    function bit is_link_type(bit [7:0] t);
      return (t == TYPE_EXT_CHS) || (t == TYPE_EXT_LBA);
    endfunction

    function void add_result(bit kind, bit [7:0] flag, bit [7:0] ptype, bit [31:0] start,
                             bit [31:0] total, bit [31:0] next, bit more, bit sig_ok,
                             bit [4:0] count, bit fin);
      part_result_t r;
      r.kind = kind;
      r.boot_flag = flag;
      r.part_type = ptype;
      r.start_lba = start;
      r.sector_total = total;
      r.next_sector_lba = next;
      r.more_to_scan = more;
      r.signature_ok = sig_ok;
      r.entries_total = count;
      r.last = fin;
      pending_q.push_back(r);
    endfunction

    // Walk the table once the last signature byte is in.
    function void close_sector(bit [7:0] sig_hi);
      bit        sig_ok;
      int        limit;
      bit        more;
      bit [31:0] next;
      bit [7:0]  ptype;
      bit [31:0] rel;
      int        e;
      sig_ok = (sig_lo == SIG_LOW_BYTE) && (sig_hi == SIG_HIGH_BYTE);
      limit = (max_entries > MaxPartitions) ? MaxPartitions : max_entries;
      more = 1'b0;
      next = 32'h0;
      if (!in_ext_sector) begin
        reported = 5'd0;
        ext_base = 32'h0;
        if (sig_ok) begin
          for (int i = 0; i < 4 && reported < limit; i++) begin
            e = 16 * i;
            ptype = tbl[e + 4];
            if (ptype == TYPE_EMPTY) continue;
            if (is_link_type(ptype)) begin
              ext_base = word_at(e + 8);
              continue;
            end
            reported++;
            add_result(KIND_ENTRY, tbl[e], ptype, word_at(e + 8), word_at(e + 12),
                       32'h0, 1'b0, 1'b1, reported, 1'b0);
          end
          if (ext_base != 0 && reported < limit) begin
            more = 1'b1;
            next = ext_base;
          end
        end
      end else if (sig_ok && reported < limit) begin
        ptype = tbl[4];
        rel = word_at(8);
        if (ptype != TYPE_EMPTY && rel != 0) begin
          reported++;
          add_result(KIND_ENTRY, tbl[0], ptype, sector_base + rel, word_at(12),
                     32'h0, 1'b0, 1'b1, reported, 1'b0);
        end
        if (is_link_type(tbl[20]) && reported < limit) begin
          more = 1'b1;
          next = ext_base + word_at(24);
        end
      end
      add_result(KIND_SUMMARY, 8'h00, 8'h00, 32'h0, 32'h0, next, more, sig_ok,
                 reported, 1'b1);
      chain_more = more;
      chain_next = next;
    endfunction

    // Called for every sector byte the block accepts.
    function void note_item(bit [7:0] b, bit first, bit ebr, bit [31:0] lba);
      int unsigned pos;
      if (first) begin
        byte_pos = 0;
        in_ext_sector = ebr;
        sector_base = lba;
      end
      if (byte_pos >= SECTOR_BYTES) return;
      pos = byte_pos;
      byte_pos++;
      if (pos >= TABLE_START && pos < SIG_OFFSET) tbl[pos - TABLE_START] = b;
      else if (pos == SIG_OFFSET) sig_lo = b;
      else if (pos == SIG_HIGH_OFFSET) close_sector(b);
    endfunction

    function int field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        return 1;
      end
      return 0;
    endfunction

    // Called for every result the block hands over.
    function void check_result(part_result_t got);
      part_result_t want;
      int           bad;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: kind %0h, entries_total %0h",
               got.kind, got.entries_total);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      bad = field_differs("kind", want.kind, got.kind)
          + field_differs("boot_flag", want.boot_flag, got.boot_flag)
          + field_differs("part_type", want.part_type, got.part_type)
          + field_differs("start_lba", want.start_lba, got.start_lba)
          + field_differs("sector_total", want.sector_total, got.sector_total)
          + field_differs("next_sector_lba", want.next_sector_lba, got.next_sector_lba)
          + field_differs("more_to_scan", want.more_to_scan, got.more_to_scan)
          + field_differs("signature_ok", want.signature_ok, got.signature_ok)
          + field_differs("entries_total", want.entries_total, got.entries_total)
          + field_differs("last", want.last, got.last);
      if (bad != 0) errors++;
    endfunction
  endclass
endpackage

module mbr_ebr_partition_parser_tb;
  import mbrp_pkg::*;
  import mbrp_check_pkg::*;

  localparam int STUCK_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  logic clk = 1'b0;
  logic rst;

  mbrp_sector_if sector_ch ();
  mbrp_result_if result_ch ();
  mbrp_cfg_if    cfg_ch ();

  mbr_ebr_partition_parser DUT (
    .clk(clk),
    .rst(rst),
    .sector(sector_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  sector_scoreboard sb;
  bit [7:0] img [512];
  int       burst_left = 0;
  bit       hold_req = 1'b0;
  int       stuck_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sector byte sender: bursts of random length separated by random gaps.
  task automatic send_byte(input bit [7:0] b, input bit first, input bit ebr,
                           input bit [31:0] lba);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        sector_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    sector_ch.valid <= 1'b1;
    sector_ch.data_byte <= b;
    sector_ch.first_byte <= first;
    sector_ch.ebr_sector <= ebr;
    sector_ch.sector_lba <= lba;
    do @(posedge clk); while (!sector_ch.ready);
    sb.note_item(b, first, ebr, lba);
    burst_left--;
  endtask

  // Sends the first count bytes of the sector image; only byte zero carries the tag.
  task automatic send_sector(input bit ebr, input bit [31:0] lba, input int count);
    for (int i = 0; i < count; i++) begin
      if (i == 0) send_byte(img[i], 1'b1, ebr, lba);
      else send_byte(img[i], 1'b0, 1'($urandom), 32'($urandom));
    end
  endtask

  // Bytes without a first-byte mark.
  task automatic send_noise(input int count);
    repeat (count) send_byte(8'($urandom), 1'b0, 1'($urandom), 32'($urandom));
  endtask

  // Waits until every expected result is out and the table walker has gone quiet.
  task automatic wait_idle();
    sector_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_max_entries(input bit [4:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.max_entries <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.max_entries = value;
  endtask

  // Random boot code, a cleared table and the given signature bytes.
  function automatic void start_image(input bit [7:0] lo, input bit [7:0] hi);
    for (int i = 0; i < 512; i++) img[i] = (i < TABLE_START) ? 8'($urandom) : 8'h00;
    img[SIG_OFFSET] = lo;
    img[SIG_HIGH_OFFSET] = hi;
  endfunction

  function automatic void put_entry(input int slot, input bit [7:0] flag,
                                    input bit [7:0] ptype, input bit [31:0] start,
                                    input bit [31:0] total);
    int e;
    e = TABLE_START + 16 * slot;
    img[e] = flag;
    for (int i = 1; i < 4; i++) img[e + i] = 8'($urandom);
    img[e + 4] = ptype;
    for (int i = 5; i < 8; i++) img[e + i] = 8'($urandom);
    for (int i = 0; i < 4; i++) begin
      img[e + 8 + i] = start[8 * i +: 8];
      img[e + 12 + i] = total[8 * i +: 8];
    end
  endfunction

  function automatic bit [7:0] pick_flag();
    case ($urandom_range(0, 2))
      0: return 8'h00;
      1: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic bit [7:0] pick_type();
    case ($urandom_range(0, 7))
      0: return TYPE_EMPTY;
      1: return TYPE_EXT_CHS;
      2: return TYPE_EXT_LBA;
      3: return 8'h83;
      4: return 8'h07;
      5: return 8'h0C;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic bit [31:0] pick_lba();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(1, 4096));
      default: return 32'($urandom);
    endcase
  endfunction

  // Mostly a good signature; otherwise one of a few damaged forms.
  function automatic void pick_signature();
    bit [7:0] lo;
    bit [7:0] hi;
    lo = SIG_LOW_BYTE;
    hi = SIG_HIGH_BYTE;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: hi = 8'hAB;
        1: lo = 8'h54;
        default: begin
          lo = 8'($urandom);
          hi = 8'($urandom);
        end
      endcase
    end
    start_image(lo, hi);
  endfunction

  // Master sector: random primaries, usually with an extended partition among them.
  function automatic void build_master();
    pick_signature();
    for (int s = 0; s < 4; s++) put_entry(s, pick_flag(), pick_type(), pick_lba(), pick_lba());
    if ($urandom_range(0, 3) != 0)
      put_entry($urandom_range(0, 3), pick_flag(),
                $urandom_range(0, 1) ? TYPE_EXT_CHS : TYPE_EXT_LBA,
                32'($urandom_range(1, 32'h00FF_FFFF)), pick_lba());
  endfunction

  // Extended sector: one logical entry and, mostly, a link onward.
  function automatic void build_ebr();
    bit [7:0]  ptype;
    bit [31:0] rel;
    pick_signature();
    ptype = pick_type();
    if (ptype == TYPE_EMPTY && $urandom_range(0, 2) != 0) ptype = 8'h83;
    rel = ($urandom_range(0, 7) == 0) ? 32'h0 : 32'($urandom_range(1, 32'hFFFF)) ;
    if ($urandom_range(0, 7) == 0) rel = 32'($urandom);
    put_entry(0, pick_flag(), ptype, rel, pick_lba());
    put_entry(1, pick_flag(),
              ($urandom_range(0, 4) != 0) ? ($urandom_range(0, 1) ? TYPE_EXT_CHS : TYPE_EXT_LBA)
                                           : pick_type(),
              pick_lba(), pick_lba());
    for (int s = 2; s < 4; s++) put_entry(s, 8'($urandom), pick_type(), pick_lba(), pick_lba());
  endfunction

  // A master sector followed by the chain of extended sectors it points to.
  // Now and then a sector is cut short and sent again from its start.
  task automatic run_scan();
    int depth;
    depth = 0;
    build_master();
    if ($urandom_range(0, 7) == 0) send_sector(1'b0, 32'($urandom), $urandom_range(1, 511));
    send_sector(1'b0, 32'($urandom), 512);
    while (sb.chain_more && depth < 6) begin
      build_ebr();
      if ($urandom_range(0, 7) == 0) send_sector(1'b1, sb.chain_next, $urandom_range(1, 511));
      send_sector(1'b1, sb.chain_next, 512);
      depth++;
    end
    if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 20));
  endtask

  // Result receiver: stall patterns of varying length, plus one long hold-off on request.
  initial begin
    int       mode;
    int       mode_left;
    int       hold_cnt;
    bit [7:0] pattern;
    mode = 0;
    mode_left = 0;
    hold_cnt = 0;
    pattern = 8'hFF;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
        pattern = 8'($urandom);
      end
      mode_left--;
      if (hold_cnt != 0) begin
        hold_cnt--;
        result_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= ($urandom_range(0, 3) != 0);
          2: result_ch.ready <= ($urandom_range(0, 4) == 0);
          default: begin
            result_ch.ready <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
        endcase
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin : result_monitor
    part_result_t seen;
    if (!rst && result_ch.valid && result_ch.ready) begin
      seen.kind = result_ch.kind;
      seen.boot_flag = result_ch.boot_flag;
      seen.part_type = result_ch.part_type;
      seen.start_lba = result_ch.start_lba;
      seen.sector_total = result_ch.sector_total;
      seen.next_sector_lba = result_ch.next_sector_lba;
      seen.more_to_scan = result_ch.more_to_scan;
      seen.signature_ok = result_ch.signature_ok;
      seen.entries_total = result_ch.entries_total;
      seen.last = result_ch.last;
      sb.check_result(seen);
    end
  end

  // Watchdog: ends the run after too many cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (sector_ch.valid && sector_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int phase;
    sb = new();
    rst <= 1'b1;
    sector_ch.valid <= 1'b0;
    sector_ch.data_byte <= 8'h00;
    sector_ch.first_byte <= 1'b0;
    sector_ch.ebr_sector <= 1'b0;
    sector_ch.sector_lba <= 32'h0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.max_entries <= 5'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Bytes before any sector start are ignored.
    write_max_entries(5'd16);
    send_noise(4);

    // Extended sector with no master seen yet: the chain base is still zero.
    start_image(SIG_LOW_BYTE, SIG_HIGH_BYTE);
    put_entry(0, 8'h80, 8'h83, 32'd100, 32'd50);
    put_entry(1, 8'h00, TYPE_EXT_CHS, 32'd200, 32'd10);
    send_sector(1'b1, 32'd1000, 512);

    // Master with every kind of slot; the later extended entry sets the chain base.
    start_image(SIG_LOW_BYTE, SIG_HIGH_BYTE);
    put_entry(0, 8'hFF, TYPE_EMPTY, 32'd63, 32'd1000);
    put_entry(1, 8'h00, TYPE_EXT_CHS, 32'h0000_0800, 32'd5);
    put_entry(2, 8'h00, 8'h83, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_entry(3, 8'h80, TYPE_EXT_LBA, 32'h0000_1000, 32'h0);
    send_sector(1'b0, 32'h0, 512);

    // Logical start that wraps past the top of the address space; link that wraps too.
    start_image(SIG_LOW_BYTE, SIG_HIGH_BYTE);
    put_entry(0, 8'hFF, 8'hFF, 32'h20, 32'h1);
    put_entry(1, 8'h00, TYPE_EXT_LBA, 32'hFFFF_FFFF, 32'h0);
    send_sector(1'b1, 32'hFFFF_FFF0, 512);

    // Empty logical entry is not reported; the link still counts.
    start_image(SIG_LOW_BYTE, SIG_HIGH_BYTE);
    put_entry(0, 8'h80, TYPE_EMPTY, 32'd77, 32'd5);
    put_entry(1, 8'h00, TYPE_EXT_CHS, 32'd300, 32'd5);
    send_sector(1'b1, sb.chain_next, 512);

    // Logical entry with a zero start is not reported; a plain link type ends the chain.
    start_image(SIG_LOW_BYTE, SIG_HIGH_BYTE);
    put_entry(0, 8'h80, 8'h07, 32'h0, 32'd5);
    put_entry(1, 8'h00, 8'h83, 32'd400, 32'd5);
    send_sector(1'b1, sb.chain_next, 512);

    // Damaged signatures on a master and on an extended sector.
    start_image(SIG_LOW_BYTE, 8'hAB);
    put_entry(0, 8'h80, 8'h83, 32'd63, 32'd100);
    put_entry(1, 8'h00, TYPE_EXT_CHS, 32'd500, 32'd100);
    send_sector(1'b0, 32'h0, 512);
    start_image(SIG_HIGH_BYTE, SIG_LOW_BYTE);
    put_entry(0, 8'h80, 8'h83, 32'd63, 32'd100);
    put_entry(1, 8'h00, TYPE_EXT_LBA, 32'd500, 32'd100);
    send_sector(1'b1, 32'd9, 512);

    // A sector restarted one byte before its end, then bytes after a full sector.
    start_image(SIG_LOW_BYTE, SIG_HIGH_BYTE);
    for (int s = 0; s < 4; s++) put_entry(s, 8'h80, 8'h0C, 32'd2048 * (s + 1), 32'd2048);
    send_sector(1'b0, 32'h0, 511);
    send_sector(1'b0, 32'h0, 512);
    send_noise(6);

    // Limit of two: the master fills it, so the extended sector reports nothing.
    wait_idle();
    write_max_entries(5'd2);
    start_image(SIG_LOW_BYTE, SIG_HIGH_BYTE);
    put_entry(0, 8'h80, 8'h83, 32'd63, 32'd10);
    put_entry(1, 8'h00, 8'h07, 32'd100, 32'd10);
    put_entry(2, 8'h00, 8'h0C, 32'd200, 32'd10);
    put_entry(3, 8'h00, TYPE_EXT_LBA, 32'd300, 32'd10);
    send_sector(1'b0, 32'h0, 512);
    start_image(SIG_LOW_BYTE, SIG_HIGH_BYTE);
    put_entry(0, 8'h80, 8'h83, 32'd63, 32'd10);
    put_entry(1, 8'h00, TYPE_EXT_CHS, 32'd100, 32'd10);
    send_sector(1'b1, 32'd300, 512);

    // Limit of zero, then the largest register value.
    wait_idle();
    write_max_entries(5'd0);
    build_master();
    send_sector(1'b0, 32'h0, 512);
    wait_idle();
    write_max_entries(5'd31);
    run_scan();

    // Random phases, each with its own limit; one of them holds the receiver off.
    phase = 0;
    while (phase < 4) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0: write_max_entries(5'd0);
        1: write_max_entries(5'd1);
        2: write_max_entries(5'd2);
        3: write_max_entries(5'd3);
        4: write_max_entries(5'd16);
        5: write_max_entries(5'd31);
        default: write_max_entries(5'($urandom_range(0, 31)));
      endcase
      if (phase == 2) begin
        // Master sectors keep coming while the receiver is held off, so the block backs up.
        hold_req = 1'b1;
        repeat (3) begin
          build_master();
          send_sector(1'b0, 32'($urandom), 512);
        end
      end
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 5) == 0) begin
          build_ebr();
          send_sector(1'b1, 32'($urandom), 512);
        end
        if ($urandom_range(0, 5) == 0) send_noise($urandom_range(1, 30));
        run_scan();
      end
      phase++;
    end

    sector_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
